// ===== rtl/vic_pkg.sv =====
// shared types and constants of the vertex index compactor
// no dependencies
package vic_pkg;

	localparam int RAW_W        = 12;
	localparam int FACET_W      = 14;
	localparam int LIMIT_W      = 13;
	localparam int CFG_DATA_W   = 14;
	localparam int CORNER_W     = 2;
	localparam int CMP_W        = 17;

	localparam logic [FACET_W-1:0]  FACETS_RESET = 14'd10923;
	localparam logic [FACET_W-1:0]  FACETS_MAX   = 14'd16383;
	localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 13'd4096;
	localparam logic [CORNER_W-1:0] CORNER_LAST  = 2'd2;

	// section tag kept with each table entry; tag zero never matches
	localparam int EPOCH_W = 6;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 6'd1;
	localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 6'd63;
	localparam logic [EPOCH_W-1:0] EPOCH_NONE  = 6'd0;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_RANGE = 2'd1,
		ERR_ATTR  = 2'd2
	} vic_err_t;

	typedef enum logic [0:0] {
		REG_FACETS = 1'b0,
		REG_LIMIT  = 1'b1
	} vic_reg_t;

endpackage

// ===== rtl/vic_channels.sv =====
// channel interfaces of the vertex index compactor: corner requests in, results out
// depends on vic_pkg
interface vic_corner_if;
	import vic_pkg::*;
	logic             valid;
	logic             ready;
	logic [RAW_W-1:0] raw_vertex_index;
	logic             surface_start;
	logic             attributes_present;

	modport source (output valid, raw_vertex_index, surface_start, attributes_present,
		input ready);
	modport sink (input valid, raw_vertex_index, surface_start, attributes_present,
		output ready);
endinterface

interface vic_result_if #(parameter int OUT_INDEX_BITS = 24);
	import vic_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [OUT_INDEX_BITS-1:0] out_index;
	logic                      new_vertex;
	logic                      section_begin;
	logic [1:0]                error_code;

	modport source (output valid, out_index, new_vertex, section_begin, error_code,
		input ready);
	modport sink (input valid, out_index, new_vertex, section_begin, error_code,
		output ready);
endinterface

// ===== rtl/vertex_index_compactor_unit.sv =====
// vertex index compactor: remaps raw vertex indices of triangle corners to compacted indices
// depends on vic_pkg and the interfaces in vic_channels.sv
//
// usage:
//  corners: one request per triangle corner (raw index, surface start, attributes present),
//    accepted when valid and ready are high at a clock edge.
//  results: one result per corner, in order (compacted index, new vertex, section begin,
//    error code); an output register holds it until the receiver takes it.
//  cfg: write enable, register index and data; write only while the block is idle.
//  path: an accepted corner passes the memory read stage, then the output register.
//  throughput: one corner per cycle absent stalls and clearing; the remap memory is read on
//    acceptance and written back on advance; the last write is forwarded to the next corner.
//  sections are told apart by a 6-bit tag stored with each entry. after reset, and when
//    the tag runs out after 63 sections, a clearing pass walks the memory one entry per
//    cycle over all RAW_VERTICES entries (4096 by default); no corner is accepted meanwhile.
//  when the receiver stalls, one result waits in the output register and one corner in the
//    memory read stage; further corners are held off with ready low.
module vertex_index_compactor_unit #(
	parameter int RAW_VERTICES   = 4096,
	parameter int OUT_INDEX_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [vic_pkg::CFG_DATA_W-1:0] cfg_data,
	vic_corner_if.sink                   corners,
	vic_result_if.source                 results
);
	import vic_pkg::*;

	localparam int ADDR_W  = $clog2(RAW_VERTICES);
	localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(RAW_VERTICES - 1);

	typedef struct packed {
		logic [EPOCH_W-1:0]        epoch;
		logic [OUT_INDEX_BITS-1:0] value;
	} entry_t;

	// configuration
	logic [FACET_W-1:0] facets_per_section_q;
	logic [LIMIT_W-1:0] raw_vertex_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			facets_per_section_q <= FACETS_RESET;
			raw_vertex_limit_q   <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (vic_reg_t'(cfg_index))
				REG_FACETS: facets_per_section_q <= cfg_data[FACET_W-1:0];
				REG_LIMIT:  raw_vertex_limit_q   <= cfg_data[LIMIT_W-1:0];
				default:    ;
			endcase
		end
	end

	// control state
	logic [CORNER_W-1:0]       corner_q;
	logic [FACET_W-1:0]        facets_q;
	logic [EPOCH_W-1:0]        epoch_q;
	logic [OUT_INDEX_BITS-1:0] emitted_q;
	logic                      sweep_q;
	logic [ADDR_W-1:0]         sweep_addr_q;
	logic                      pend_q;
	logic [ADDR_W-1:0]         pend_addr_q;
	logic [OUT_INDEX_BITS-1:0] pend_value_q;
	logic                      fwd_q;
	logic [ADDR_W-1:0]         fwd_addr_q;
	entry_t                    fwd_entry_q;

	// read stage
	logic                      valid_s1;
	logic [ADDR_W-1:0]         addr_s1;
	logic                      oor_s1;
	logic                      attr_s1;
	logic                      begin_s1;
	logic [EPOCH_W-1:0]        epoch_s1;
	logic                      wrap_s1;

	// output register
	logic                      out_valid_q;
	logic [OUT_INDEX_BITS-1:0] out_index_q;
	logic                      out_new_q;
	logic                      out_begin_q;
	vic_err_t                  out_err_q;

	// memory
	entry_t mem [RAW_VERTICES];
	entry_t rdata_q;
	logic   mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	entry_t mem_wdata;

	// acceptance side
	logic                      accept;
	logic                      advance;
	logic [FACET_W-1:0]        limit;
	logic                      begin_c;
	logic                      wrap_c;
	logic [RAW_W+ADDR_W-1:0]   raw_wide;
	logic [ADDR_W-1:0]         raw_addr;
	logic                      oor_c;
	logic [CORNER_W-1:0]       corner_base;
	logic [FACET_W-1:0]        facets_base;

	assign advance = valid_s1 && (!out_valid_q || results.ready);
	assign corners.ready = !sweep_q && !(valid_s1 && wrap_s1) && (!valid_s1 || advance);
	assign accept  = corners.valid && corners.ready;

	assign limit   = (facets_per_section_q == '0) ? FACET_W'(1) : facets_per_section_q;
	assign begin_c = corners.surface_start || (corner_q == '0 && facets_q >= limit);
	assign wrap_c  = begin_c && epoch_q == EPOCH_LAST;
	assign raw_wide = (RAW_W+ADDR_W)'(corners.raw_vertex_index);
	assign raw_addr = raw_wide[ADDR_W-1:0];
	assign oor_c = (CMP_W'(corners.raw_vertex_index) >= CMP_W'(raw_vertex_limit_q))
		|| (CMP_W'(corners.raw_vertex_index) >= CMP_W'(RAW_VERTICES));
	assign corner_base = begin_c ? '0 : corner_q;
	assign facets_base = begin_c ? '0 : facets_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_q <= '0;
			facets_q <= '0;
			epoch_q  <= EPOCH_FIRST;
		end else if (accept) begin
			if (corner_base == CORNER_LAST) begin
				corner_q <= '0;
				facets_q <= (facets_base < FACETS_MAX) ? facets_base + 1'b1 : facets_base;
			end else begin
				corner_q <= corner_base + 1'b1;
				facets_q <= facets_base;
			end
			if (begin_c)
				epoch_q <= wrap_c ? EPOCH_FIRST : epoch_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1  <= raw_addr;
			oor_s1   <= oor_c;
			attr_s1  <= corners.attributes_present;
			begin_s1 <= begin_c;
			epoch_s1 <= wrap_c ? EPOCH_FIRST : (begin_c ? epoch_q + 1'b1 : epoch_q);
			wrap_s1  <= wrap_c;
		end
	end

	// lookup and allocation
	entry_t   look;
	logic     hit;
	logic     alloc;
	vic_err_t err_c;
	logic [OUT_INDEX_BITS-1:0] idx_c;

	always_comb begin
		look  = (fwd_q && fwd_addr_q == addr_s1) ? fwd_entry_q : rdata_q;
		hit   = !wrap_s1 && look.epoch == epoch_s1;
		alloc = 1'b0;
		err_c = ERR_NONE;
		idx_c = '0;
		if (oor_s1) begin
			err_c = ERR_RANGE;
		end else if (hit) begin
			idx_c = look.value;
		end else if (!attr_s1) begin
			err_c = ERR_ATTR;
		end else begin
			idx_c = emitted_q;
			alloc = 1'b1;
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_s1;
		mem_wdata = '{epoch: epoch_s1, value: emitted_q};
		if (sweep_q) begin
			mem_we    = 1'b1;
			mem_waddr = sweep_addr_q;
			if (pend_q && sweep_addr_q == pend_addr_q)
				mem_wdata = '{epoch: EPOCH_FIRST, value: pend_value_q};
			else
				mem_wdata = '{epoch: EPOCH_NONE, value: '0};
		end else if (advance && alloc && !wrap_s1) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (accept)
			rdata_q <= mem[raw_addr];
	end

	// forward the write made at the same edge as a read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fwd_q <= 1'b0;
		else if (accept)
			fwd_q <= mem_we && !sweep_q;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fwd_addr_q  <= mem_waddr;
			fwd_entry_q <= mem_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			emitted_q <= '0;
		else if (advance && alloc)
			emitted_q <= emitted_q + 1'b1;
	end

	// clearing pass, after reset and on tag wrap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q      <= 1'b1;
			sweep_addr_q <= '0;
			pend_q       <= 1'b0;
		end else if (sweep_q) begin
			if (sweep_addr_q == ADDR_LAST) begin
				sweep_q <= 1'b0;
				pend_q  <= 1'b0;
			end
			sweep_addr_q <= sweep_addr_q + 1'b1;
		end else if (advance && wrap_s1) begin
			sweep_q      <= 1'b1;
			sweep_addr_q <= '0;
			pend_q       <= alloc;
		end
	end

	always_ff @(posedge clk) begin
		if (!sweep_q && advance && wrap_s1) begin
			pend_addr_q  <= addr_s1;
			pend_value_q <= emitted_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (results.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_index_q <= idx_c;
			out_new_q   <= alloc;
			out_begin_q <= begin_s1;
			out_err_q   <= err_c;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.out_index     = out_index_q;
	assign results.new_vertex    = out_new_q;
	assign results.section_begin = out_begin_q;
	assign results.error_code    = out_err_q;

endmodule
